>>> hdl/awb_pkg.sv
// shared constants for the affine warp bilinear block
package awb_pkg;

    // field widths
    localparam int COEF_W  = 32;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int LDA_W   = 9;
    localparam int OUTC_W  = 12;
    localparam int FRAC_W  = 16;
    localparam int CFGI_W  = 3;
    localparam int SIZE_W  = 10;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_WARP = 1'b1;

    // register indexes
    localparam logic [CFGI_W-1:0] CFG_ROW_ROW  = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_ROW_COL  = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_ROW_OFF  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_COL_ROW  = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_COL_COL  = 3'd4;
    localparam logic [CFGI_W-1:0] CFG_COL_OFF  = 3'd5;
    localparam logic [CFGI_W-1:0] CFG_SRC_ROWS = 3'd6;
    localparam logic [CFGI_W-1:0] CFG_SRC_COLS = 3'd7;

    typedef logic [PIX_W-1:0] t_pix;

endpackage

>>> hdl/awb_bank.sv
// one parity bank of the source image store, one write and one read port
module awb_bank
    import awb_pkg::*;
#(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_pix          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_pix          o_rd_data
);

    t_pix r_mem [0:(1<<AW)-1];
    t_pix r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/affine_warp_bilinear.sv
// top level of the affine warp bilinear block
// Takes one beat per clock while not stalled, load or warp, and returns one result beat
// per warp beat after its stages: products, position sum, neighbor and bound check,
// store read, weights, channel products, final sum. The source image lives in four
// banks split by row and column parity, each with one write and one read port, so the
// four neighbors of a position are read in the same cycle. Loads write the store at the
// same stage where warps read it, so a warp sees every load accepted before it. A
// stall on the result side holds the whole pipeline and stalls the input side.
module affine_warp_bilinear
    import awb_pkg::*;
#(
    parameter int SRC_MAX_ROWS     = 512,
    parameter int SRC_MAX_COLS     = 512,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_req_type,
    input  logic [LDA_W-1:0]         i_src_row,
    input  logic [LDA_W-1:0]         i_src_col,
    input  logic [CH_W-1:0]          i_in_red,
    input  logic [CH_W-1:0]          i_in_green,
    input  logic [CH_W-1:0]          i_in_blue,
    input  logic [OUTC_W-1:0]        i_out_row,
    input  logic [OUTC_W-1:0]        i_out_col,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CH_W-1:0]          o_out_red,
    output logic [CH_W-1:0]          o_out_green,
    output logic [CH_W-1:0]          o_out_blue,
    output logic                     o_covered,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFGI_W-1:0]        i_cfg_index,
    input  logic [COEF_W-1:0]        i_cfg_data
);

    localparam int W    = WEIGHT_FRAC_BITS;
    localparam int RB   = (SRC_MAX_ROWS > 2) ? $clog2(SRC_MAX_ROWS) : 2;
    localparam int CB   = (SRC_MAX_COLS > 2) ? $clog2(SRC_MAX_COLS) : 2;
    localparam int AW   = RB + CB - 2;
    localparam int RLW  = ($clog2(SRC_MAX_ROWS + 1) > SIZE_W) ? $clog2(SRC_MAX_ROWS + 1) : SIZE_W;
    localparam int CLW  = ($clog2(SRC_MAX_COLS + 1) > SIZE_W) ? $clog2(SRC_MAX_COLS + 1) : SIZE_W;
    localparam int PW   = COEF_W + OUTC_W + 1;
    localparam int POSW = PW + 2;
    localparam int IW   = POSW - FRAC_W;
    localparam int WPW  = 2 * W + 2;
    localparam int PRW  = WPW + CH_W;
    localparam int SUMW = PRW + 2;

    localparam logic [RLW-1:0] ROWS_MAX = RLW'(SRC_MAX_ROWS);
    localparam logic [CLW-1:0] COLS_MAX = CLW'(SRC_MAX_COLS);
    localparam logic [RLW-1:0] ROWS_RST = (SRC_MAX_ROWS < 512) ? RLW'(SRC_MAX_ROWS) : RLW'(512);
    localparam logic [CLW-1:0] COLS_RST = (SRC_MAX_COLS < 512) ? CLW'(SRC_MAX_COLS) : CLW'(512);
    localparam logic [W:0]     S_ONE    = (W+1)'(1) << W;
    localparam logic [SUMW-1:0] ROUND   = SUMW'(1) << (2 * W - 1);

    // pipeline advance
    logic en;
    logic r_o_valid;
    assign en          = ~(r_o_valid & i_out_stall);
    assign o_in_stall  = ~en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    logic signed [COEF_W-1:0] r_c_rr, r_c_rc, r_c_ro, r_c_cr, r_c_cc, r_c_co;
    logic [RLW-1:0] r_rows_lim;
    logic [CLW-1:0] r_cols_lim;
    logic [RLW-1:0] n_rows_lim;
    logic [CLW-1:0] n_cols_lim;

    always_comb begin
        n_rows_lim = RLW'(i_cfg_data[SIZE_W-1:0]);
        n_cols_lim = CLW'(i_cfg_data[SIZE_W-1:0]);
        if (n_rows_lim > ROWS_MAX) begin
            n_rows_lim = ROWS_MAX;
        end
        if (n_cols_lim > COLS_MAX) begin
            n_cols_lim = COLS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_rr     <= COEF_W'(65536);
            r_c_rc     <= '0;
            r_c_ro     <= '0;
            r_c_cr     <= '0;
            r_c_cc     <= COEF_W'(65536);
            r_c_co     <= '0;
            r_rows_lim <= ROWS_RST;
            r_cols_lim <= COLS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_ROW:  r_c_rr     <= i_cfg_data;
                CFG_ROW_COL:  r_c_rc     <= i_cfg_data;
                CFG_ROW_OFF:  r_c_ro     <= i_cfg_data;
                CFG_COL_ROW:  r_c_cr     <= i_cfg_data;
                CFG_COL_COL:  r_c_cc     <= i_cfg_data;
                CFG_COL_OFF:  r_c_co     <= i_cfg_data;
                CFG_SRC_ROWS: r_rows_lim <= n_rows_lim;
                CFG_SRC_COLS: r_cols_lim <= n_cols_lim;
                default: ;
            endcase
        end
    end

    // stage 1: coefficient products, load beat capture
    logic r1_v, r1_warp, r1_ldok;
    logic signed [PW-1:0] r1_prr, r1_prc, r1_pcr, r1_pcc;
    logic [LDA_W-1:0] r1_ldr, r1_ldc;
    t_pix r1_pix;
    logic signed [OUTC_W:0] orow_s, ocol_s;
    assign orow_s = $signed({1'b0, i_out_row});
    assign ocol_s = $signed({1'b0, i_out_col});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_warp <= (i_req_type == REQ_WARP);
            r1_ldok <= (32'(i_src_row) < SRC_MAX_ROWS) && (32'(i_src_col) < SRC_MAX_COLS);
            r1_ldr  <= i_src_row;
            r1_ldc  <= i_src_col;
            r1_pix  <= {i_in_red, i_in_green, i_in_blue};
            r1_prr  <= r_c_rr * orow_s;
            r1_prc  <= r_c_rc * ocol_s;
            r1_pcr  <= r_c_cr * orow_s;
            r1_pcc  <= r_c_cc * ocol_s;
        end
    end

    // stage 2: source position sums
    logic r2_v, r2_warp, r2_ldok;
    logic signed [POSW-1:0] r2_px, r2_py;
    logic [LDA_W-1:0] r2_ldr, r2_ldc;
    t_pix r2_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_warp <= r1_warp;
            r2_ldok <= r1_ldok;
            r2_ldr  <= r1_ldr;
            r2_ldc  <= r1_ldc;
            r2_pix  <= r1_pix;
            r2_px   <= POSW'(r1_prr) + POSW'(r1_prc) + POSW'(r_c_ro);
            r2_py   <= POSW'(r1_pcr) + POSW'(r1_pcc) + POSW'(r_c_co);
        end
    end

    // stage 3: floor, fraction, bound check and bank addresses
    logic signed [IW-1:0] x1, y1;
    logic signed [IW:0]   x2, y2;
    logic fxnz, fynz, n3_cov;
    logic [RB-1:0] x1p1;
    logic [CB-1:0] y1p1;
    assign x1   = r2_px[POSW-1:FRAC_W];
    assign y1   = r2_py[POSW-1:FRAC_W];
    assign fxnz = |r2_px[FRAC_W-1:0];
    assign fynz = |r2_py[FRAC_W-1:0];
    assign x2   = (IW+1)'(x1) + (IW+1)'(fxnz);
    assign y2   = (IW+1)'(y1) + (IW+1)'(fynz);
    assign x1p1 = x1[RB-1:0] + RB'(1);
    assign y1p1 = y1[CB-1:0] + CB'(1);
    assign n3_cov = ~x1[IW-1] && ~y1[IW-1]
                 && (x2 < $signed((IW+1)'(r_rows_lim)))
                 && (y2 < $signed((IW+1)'(r_cols_lim)));

    logic r3_v, r3_warp, r3_ldok, r3_cov;
    logic [W-1:0] r3_l, r3_m;
    logic r3_xp1, r3_xp2, r3_yp1, r3_yp2;
    logic [RB-2:0] r3_rh [2];
    logic [CB-2:0] r3_ch [2];
    logic [LDA_W-1:0] r3_ldr, r3_ldc;
    t_pix r3_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_warp <= r2_warp;
            r3_ldok <= r2_ldok;
            r3_ldr  <= r2_ldr;
            r3_ldc  <= r2_ldc;
            r3_pix  <= r2_pix;
            r3_cov  <= n3_cov;
            r3_l    <= r2_px[FRAC_W-1 -: W];
            r3_m    <= r2_py[FRAC_W-1 -: W];
            r3_xp1  <= x1[0];
            r3_xp2  <= x1[0] ^ fxnz;
            r3_yp1  <= y1[0];
            r3_yp2  <= y1[0] ^ fynz;
            for (int b = 0; b < 2; b++) begin
                r3_rh[b] <= (x1[0] == 1'(b)) ? x1[RB-1:1] : x1p1[RB-1:1];
                r3_ch[b] <= (y1[0] == 1'(b)) ? y1[CB-1:1] : y1p1[CB-1:1];
            end
        end
    end

    // source store: four parity banks, loads write here, warps read here
    logic [RB+LDA_W-1:0] ldr_x;
    logic [CB+LDA_W-1:0] ldc_x;
    logic [RB-1:0] ld_r;
    logic [CB-1:0] ld_c;
    logic ld_wr;
    t_pix bank_q [4];
    assign ldr_x = (RB+LDA_W)'(r3_ldr);
    assign ldc_x = (CB+LDA_W)'(r3_ldc);
    assign ld_r  = ldr_x[RB-1:0];
    assign ld_c  = ldc_x[CB-1:0];
    assign ld_wr = en & r3_v & ~r3_warp & r3_ldok;

    for (genvar g = 0; g < 4; g++) begin : g_bank
        awb_bank #(.AW(AW)) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (ld_wr && ({ld_r[0], ld_c[0]} == 2'(g))),
            .i_wr_addr ({ld_r[RB-1:1], ld_c[CB-1:1]}),
            .i_wr_data (r3_pix),
            .i_rd_en   (en),
            .i_rd_addr ({r3_rh[g/2], r3_ch[g%2]}),
            .o_rd_data (bank_q[g])
        );
    end

    // stage 4: metadata alongside the read data
    logic r4_v, r4_cov;
    logic [W-1:0] r4_l, r4_m;
    logic r4_xp1, r4_xp2, r4_yp1, r4_yp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v & r3_warp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cov <= r3_cov;
            r4_l   <= r3_l;
            r4_m   <= r3_m;
            r4_xp1 <= r3_xp1;
            r4_xp2 <= r3_xp2;
            r4_yp1 <= r3_yp1;
            r4_yp2 <= r3_yp2;
        end
    end

    // stage 5: neighbor select and weight products
    logic [W:0] wl0, wl1, wm0, wm1;
    assign wl1 = {1'b0, r4_l};
    assign wm1 = {1'b0, r4_m};
    assign wl0 = S_ONE - wl1;
    assign wm0 = S_ONE - wm1;

    logic r5_v, r5_cov;
    t_pix r5_pix [4];
    logic [WPW-1:0] r5_w [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_cov    <= r4_cov;
            r5_pix[0] <= bank_q[{r4_xp1, r4_yp1}];
            r5_pix[1] <= bank_q[{r4_xp1, r4_yp2}];
            r5_pix[2] <= bank_q[{r4_xp2, r4_yp1}];
            r5_pix[3] <= bank_q[{r4_xp2, r4_yp2}];
            r5_w[0]   <= WPW'(wl0) * WPW'(wm0);
            r5_w[1]   <= WPW'(wl0) * WPW'(wm1);
            r5_w[2]   <= WPW'(wl1) * WPW'(wm0);
            r5_w[3]   <= WPW'(wl1) * WPW'(wm1);
        end
    end

    // stage 6: weighted channel products
    logic r6_v, r6_cov;
    logic [PRW-1:0] r6_p [4][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_cov <= r5_cov;
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r6_p[k][c] <= PRW'(r5_w[k]) * PRW'(r5_pix[k][CH_W*(2-c) +: CH_W]);
                end
            end
        end
    end

    // stage 7: sum, round and output register
    logic [SUMW-1:0] sum [3];
    logic [CH_W-1:0] n_ch [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c]  = SUMW'(r6_p[0][c]) + SUMW'(r6_p[1][c]) + SUMW'(r6_p[2][c])
                    + SUMW'(r6_p[3][c]) + ROUND;
            n_ch[c] = r6_cov ? sum[c][2*W +: CH_W] : '0;
        end
    end

    logic [CH_W-1:0] r_o_red, r_o_green, r_o_blue;
    logic r_o_cov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_red   <= n_ch[0];
            r_o_green <= n_ch[1];
            r_o_blue  <= n_ch[2];
            r_o_cov   <= r6_cov;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_red   = r_o_red;
    assign o_out_green = r_o_green;
    assign o_out_blue  = r_o_blue;
    assign o_covered   = r_o_cov;

endmodule

>>> tb/affine_warp_bilinear_test.sv
// self-checking testbench for the affine warp bilinear block
module affine_warp_bilinear_test;
    import awb_pkg::*;

    localparam int STORE_DIM  = 512;
    localparam int IMG_EDGE   = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int PIPE_DEPTH = 12;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            cov;
    } t_warp_px;

    // predicts warp results and holds them until the block returns them
    class warp_scoreboard;
        bit [PIX_W-1:0] image[0:STORE_DIM*STORE_DIM-1];
        bit             loaded[0:STORE_DIM*STORE_DIM-1];
        longint         coef[6];
        int             rows_reg;
        int             cols_reg;
        t_warp_px       due[$];
        int             errors;

        function new();
            coef = '{65536, 0, 0, 0, 65536, 0};
            rows_reg = 512;
            cols_reg = 512;
            errors = 0;
        endfunction

        function void set_reg(logic [CFGI_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_ROW_ROW:  coef[0] = longint'(signed'(data));
                CFG_ROW_COL:  coef[1] = longint'(signed'(data));
                CFG_ROW_OFF:  coef[2] = longint'(signed'(data));
                CFG_COL_ROW:  coef[3] = longint'(signed'(data));
                CFG_COL_COL:  coef[4] = longint'(signed'(data));
                CFG_COL_OFF:  coef[5] = longint'(signed'(data));
                CFG_SRC_ROWS: rows_reg = int'(data[SIZE_W-1:0]);
                CFG_SRC_COLS: cols_reg = int'(data[SIZE_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint mix(longint a, longint b, longint c, longint d, longint l, longint m);
            longint acc;
            acc = (256 - l) * (256 - m) * a + (256 - l) * m * b + l * (256 - m) * c
                + l * m * d + 32768;
            return (acc >>> 16) & 255;
        endfunction

        // returns 0 when the warp would touch a pixel never loaded
        function bit warp_at(logic [OUTC_W-1:0] orow, logic [OUTC_W-1:0] ocol,
                             output t_warp_px res);
            longint r, c, pr, pc, x1, y1, fx, fy, x2, y2, lr, lc;
            int     a00, a01, a10, a11;
            r  = longint'(orow);
            c  = longint'(ocol);
            pr = coef[0] * r + coef[1] * c + coef[2];
            pc = coef[3] * r + coef[4] * c + coef[5];
            x1 = pr >>> 16;
            y1 = pc >>> 16;
            fx = pr & 65535;
            fy = pc & 65535;
            x2 = x1 + (fx != 0);
            y2 = y1 + (fy != 0);
            lr = rows_reg > STORE_DIM ? STORE_DIM : rows_reg;
            lc = cols_reg > STORE_DIM ? STORE_DIM : cols_reg;
            res = '0;
            if (!(x1 >= 0 && x2 < lr && y1 >= 0 && y2 < lc)) return 1;
            a00 = int'(x1 * STORE_DIM + y1);
            a01 = int'(x1 * STORE_DIM + y2);
            a10 = int'(x2 * STORE_DIM + y1);
            a11 = int'(x2 * STORE_DIM + y2);
            if (!(loaded[a00] && loaded[a01] && loaded[a10] && loaded[a11])) return 0;
            fx = fx >> 8;
            fy = fy >> 8;
            res.red   = CH_W'(mix(image[a00][23:16], image[a01][23:16], image[a10][23:16],
                                  image[a11][23:16], fx, fy));
            res.green = CH_W'(mix(image[a00][15:8], image[a01][15:8], image[a10][15:8],
                                  image[a11][15:8], fx, fy));
            res.blue  = CH_W'(mix(image[a00][7:0], image[a01][7:0], image[a10][7:0],
                                  image[a11][7:0], fx, fy));
            res.cov   = 1'b1;
            return 1;
        endfunction

        function void note_input(logic rtype, logic [LDA_W-1:0] row, logic [LDA_W-1:0] col,
                                 logic [PIX_W-1:0] rgb, logic [OUTC_W-1:0] orow,
                                 logic [OUTC_W-1:0] ocol);
            t_warp_px res;
            if (rtype == REQ_LOAD) begin
                image[row * STORE_DIM + col]  = rgb;
                loaded[row * STORE_DIM + col] = 1'b1;
            end else begin
                void'(warp_at(orow, ocol, res));
                due = {due, res};
            end
        endfunction

        function void check_result(t_warp_px got);
            t_warp_px want;
            if (due.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                errors++;
            end
            if (got.cov !== want.cov) begin
                $display("%0t: covered expected %0d actual %0d", $time, want.cov, got.cov);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_req_type = REQ_LOAD;
    logic [LDA_W-1:0]   i_src_row = '0;
    logic [LDA_W-1:0]   i_src_col = '0;
    logic [CH_W-1:0]    i_in_red = '0;
    logic [CH_W-1:0]    i_in_green = '0;
    logic [CH_W-1:0]    i_in_blue = '0;
    logic [OUTC_W-1:0]  i_out_row = '0;
    logic [OUTC_W-1:0]  i_out_col = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [CH_W-1:0]    o_out_red;
    logic [CH_W-1:0]    o_out_green;
    logic [CH_W-1:0]    o_out_blue;
    logic               o_covered;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFGI_W-1:0]  i_cfg_index = '0;
    logic [COEF_W-1:0]  i_cfg_data = '0;

    warp_scoreboard sb = new();
    bit             quiet = 1'b0;
    bit             long_hold_req = 1'b0;
    int             cycles = 0;

    affine_warp_bilinear dut (.*);

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("affine_warp_bilinear test failed");
            $finish;
        end
    end

    // result side check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_out_red, o_out_green, o_out_blue, o_covered});
    end

    // receiver stall: random bursts plus one long hold on request
    initial begin
        int hold;
        int burst;
        hold = 0;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && hold == 0) begin
                hold = 80;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // drive one input beat and wait until it is taken
    task automatic send_beat(logic rtype, logic [LDA_W-1:0] row, logic [LDA_W-1:0] col,
                             logic [PIX_W-1:0] rgb, logic [OUTC_W-1:0] orow,
                             logic [OUTC_W-1:0] ocol);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rtype;
        i_src_row  <= row;
        i_src_col  <= col;
        i_in_red   <= rgb[23:16];
        i_in_green <= rgb[15:8];
        i_in_blue  <= rgb[7:0];
        i_out_row  <= orow;
        i_out_col  <= ocol;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(rtype, row, col, rgb, orow, ocol);
    endtask

    task automatic send_load(logic [LDA_W-1:0] row, logic [LDA_W-1:0] col,
                             logic [PIX_W-1:0] rgb);
        send_beat(REQ_LOAD, row, col, rgb, OUTC_W'($urandom), OUTC_W'($urandom));
    endtask

    task automatic send_warp(logic [OUTC_W-1:0] orow, logic [OUTC_W-1:0] ocol);
        send_beat(REQ_WARP, LDA_W'($urandom), LDA_W'($urandom), PIX_W'($urandom), orow, ocol);
    endtask

    // random warp that only reads loaded pixels, else a load
    task automatic send_random_warp();
        t_warp_px dummy;
        logic [OUTC_W-1:0] r;
        logic [OUTC_W-1:0] c;
        for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                r = OUTC_W'($urandom_range(0, 20));
                c = OUTC_W'($urandom_range(0, 20));
            end else begin
                r = OUTC_W'($urandom);
                c = OUTC_W'($urandom);
            end
            if (sb.warp_at(r, c, dummy)) begin
                send_warp(r, c);
                return;
            end
        end
        send_load(LDA_W'($urandom_range(0, IMG_EDGE - 1)),
                  LDA_W'($urandom_range(0, IMG_EDGE - 1)), PIX_W'($urandom));
    endtask

    task automatic random_beat();
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0)
                send_load(LDA_W'($urandom_range(0, IMG_EDGE - 1)),
                          LDA_W'($urandom_range(0, IMG_EDGE - 1)), PIX_W'($urandom));
            else
                send_load(LDA_W'($urandom), LDA_W'($urandom), PIX_W'($urandom));
        end else begin
            send_random_warp();
        end
    endtask

    // wait until every expected result is back, then let loads flush
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // all eight registers, size registers with random upper bits
    task automatic apply_config(logic [COEF_W-1:0] rr, logic [COEF_W-1:0] rc,
                                logic [COEF_W-1:0] ro, logic [COEF_W-1:0] cr,
                                logic [COEF_W-1:0] cc, logic [COEF_W-1:0] co,
                                int rows, int cols);
        logic [COEF_W-1:0] hi;
        drain();
        write_reg(CFG_ROW_ROW, rr);
        write_reg(CFG_ROW_COL, rc);
        write_reg(CFG_ROW_OFF, ro);
        write_reg(CFG_COL_ROW, cr);
        write_reg(CFG_COL_COL, cc);
        write_reg(CFG_COL_OFF, co);
        hi = $urandom;
        write_reg(CFG_SRC_ROWS, {hi[COEF_W-1:SIZE_W], SIZE_W'(rows)});
        hi = $urandom;
        write_reg(CFG_SRC_COLS, {hi[COEF_W-1:SIZE_W], SIZE_W'(cols)});
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: store corners and identity warps at the edges
        send_load(0, 0, 24'h000000);
        send_load(511, 511, 24'hFFFFFF);
        send_load(0, 511, 24'hFF00FF);
        send_load(511, 0, 24'h00FF00);
        send_load(510, 510, 24'h123456);
        send_load(510, 511, 24'hABCDEF);
        send_load(511, 510, 24'h0F0F0F);
        send_warp(0, 0);
        send_warp(511, 511);
        send_warp(0, 511);
        send_warp(511, 0);
        send_warp(510, 510);
        send_warp(512, 0);
        send_warp(0, 512);
        send_warp(4095, 4095);

        // fill the working image
        for (int r = 0; r < IMG_EDGE; r++)
            for (int c = 0; c < IMG_EDGE; c++)
                send_load(LDA_W'(r), LDA_W'(c), PIX_W'($urandom));

        // row shift of 1.5 pixels and a fractional column shift
        apply_config(32'h10000, 0, 32'h18000, 0, 32'h10000, 32'h4C00, IMG_EDGE, IMG_EDGE);
        send_warp(0, 0);
        send_warp(14, 14);
        send_warp(15, 0);
        for (int i = 0; i < 120; i++) random_beat();

        // scale with cross terms, column size clamped to the store; long receiver hold
        apply_config(32'hC000, 32'h1800, 32'h3000, 32'hFFFFF000, 32'hB000, 32'h24000,
                     IMG_EDGE, 1023);
        for (int i = 0; i < 130; i++) begin
            if (i == 30) long_hold_req = 1'b1;
            random_beat();
        end

        // extreme coefficients
        apply_config(32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF, 0, 512, 512);
        send_warp(0, 0);
        send_warp(1, 0);
        send_warp(0, 1);
        send_warp(4095, 4095);
        for (int i = 0; i < 100; i++) random_beat();

        // mirrored, sender pauses mid-phase until all results are back
        apply_config(32'hFFFF0000, 0, 32'hF8000, 0, 32'hFFFF8000, 32'hE0000, IMG_EDGE, IMG_EDGE);
        for (int i = 0; i < 120; i++) begin
            if (i == 60) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (sb.due.size() != 0) @(posedge i_clk);
            end
            random_beat();
        end

        // one-pixel source
        apply_config(32'h10000, 0, 0, 0, 32'h10000, 0, 1, 1);
        send_warp(0, 0);
        send_warp(0, 1);
        for (int i = 0; i < 60; i++) random_beat();

        // empty source covers nothing
        apply_config(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0);
        send_warp(0, 0);
        for (int i = 0; i < 60; i++) random_beat();

        // random mild transforms
        for (int p = 0; p < 3; p++) begin
            apply_config(32'h8000 + $urandom_range(0, 32'h10000),
                         $urandom_range(0, 32'h4000) - 32'h2000,
                         $urandom_range(0, 32'h40000),
                         $urandom_range(0, 32'h4000) - 32'h2000,
                         32'h8000 + $urandom_range(0, 32'h10000),
                         $urandom_range(0, 32'h40000),
                         IMG_EDGE, IMG_EDGE);
            if (p == 2) quiet = 1'b1;
            for (int i = 0; i < 60; i++) random_beat();
        end

        // wind down
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
        if (sb.errors == 0)
            $display("affine_warp_bilinear test passed");
        else
            $display("affine_warp_bilinear test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/awb_pkg.sv
hdl/awb_bank.sv
hdl/affine_warp_bilinear.sv
tb/affine_warp_bilinear_test.sv
